[src/lkfr_pkg.sv]
// ----------------------------------------------------------------------------
// LRU-K frame replacer package
// Shared types and fixed widths for the LRU-K frame replacer.
// ----------------------------------------------------------------------------
package lkfr_pkg;

  // Fixed field widths.
  localparam int OP_W     = 2;
  localparam int FRAME_W  = 6;
  localparam int COUNT_W  = 7;
  localparam int K_W      = 4;
  localparam int TIME_W   = 48;

  // Number of tracked frames and the deepest kept history.
  localparam int FRAME_CNT = 64;
  localparam int MAX_K     = 8;

  // Operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_ACCESS = 2'd0,
    OP_SET    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_EVICT  = 2'd3
  } op_t;

  // One classified command word held in the queue.
  typedef struct packed {
    op_t                op;
    logic [FRAME_W-1:0] frame;
    logic               evictable;
    logic               frame_ok;
  } cmd_t;

  // Queue head as seen by the back end.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

  // Back end sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_EVWR,
    ST_DONE
  } state_t;

endpackage

[src/lkfr_if.sv]
// ----------------------------------------------------------------------------
// LRU-K frame replacer channels
// Valid/ready channel interfaces for commands, results and configuration.
// ----------------------------------------------------------------------------
interface lkfr_in_if;
  logic                          valid;
  logic                          ready;
  logic [lkfr_pkg::OP_W-1:0]     op;
  logic [lkfr_pkg::FRAME_W-1:0]  frame;
  logic                          evictable;
  modport source (output valid, output op, output frame, output evictable, input ready);
  modport sink   (input valid, input op, input frame, input evictable, output ready);
endinterface

interface lkfr_out_if;
  logic                          valid;
  logic                          ready;
  logic                          ok;
  logic [lkfr_pkg::FRAME_W-1:0]  victim_frame;
  logic [lkfr_pkg::COUNT_W-1:0]  evictable_count;
  modport source (output valid, output ok, output victim_frame, output evictable_count,
                  input ready);
  modport sink   (input valid, input ok, input victim_frame, input evictable_count,
                  output ready);
endinterface

interface lkfr_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [lkfr_pkg::K_W-1:0]  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/lkfr_front.sv]
// ----------------------------------------------------------------------------
// LRU-K frame replacer front end
// Accepts command words, checks the frame bound and queues them.
// ----------------------------------------------------------------------------
module lkfr_front (
  input  logic             clk,
  input  logic             rst_n,
  lkfr_in_if.sink          in_ch,
  output lkfr_pkg::head_t  head,
  input  logic             pop
);

  localparam int DEPTH = 2;

  lkfr_pkg::cmd_t q_r [DEPTH];
  logic [1:0]     cnt_r, cnt_nxt;
  logic           push;
  logic           to_head;
  lkfr_pkg::cmd_t cls;

  // Classify the incoming word.
  always_comb begin
    cls.op        = lkfr_pkg::op_t'(in_ch.op);
    cls.frame     = in_ch.frame;
    cls.evictable = in_ch.evictable;
    cls.frame_ok  = (11'(in_ch.frame) < 11'(lkfr_pkg::FRAME_CNT));
  end

  assign in_ch.ready = (cnt_r < 2'(DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign head.valid  = (cnt_r != 2'd0);
  assign head.cmd    = q_r[0];

  // A pushed word lands at the head when the queue is empty or drains to empty.
  assign to_head = (cnt_r == 2'd0) || (pop && (cnt_r == 2'd1));

  // Occupancy count.
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Two-entry shift queue; entry 0 is the head.
  always_ff @(posedge clk) begin
    if (push && to_head) begin
      q_r[0] <= cls;
    end else if (pop) begin
      q_r[0] <= q_r[1];
    end
    if (push && !to_head) begin
      q_r[1] <= cls;
    end
  end

endmodule

[src/lkfr_back.sv]
// ----------------------------------------------------------------------------
// LRU-K frame replacer back end
// Sequencer holding frame state and history memories; runs one command at
// a time and drives the result register.
// ----------------------------------------------------------------------------
module lkfr_back (
  input  logic             clk,
  input  logic             rst_n,
  input  lkfr_pkg::head_t  head,
  output logic             pop,
  lkfr_cfg_if.sink         cfg_ch,
  lkfr_out_if.source       out_ch
);

  localparam int FRAME_CNT = lkfr_pkg::FRAME_CNT;
  localparam int MAX_K     = lkfr_pkg::MAX_K;
  localparam int FW   = $clog2(FRAME_CNT);
  localparam int TW   = $clog2(FRAME_CNT + 1);
  localparam int CW   = $clog2(MAX_K + 1);
  localparam int SW   = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int MW   = CW + SW;
  localparam int AW   = (FRAME_CNT * MAX_K > 1) ? $clog2(FRAME_CNT * MAX_K) : 1;
  localparam int SUMW = $clog2(2 * MAX_K) + 1;
  localparam int TIW  = lkfr_pkg::TIME_W;

  // Memories: per-frame count and oldest slot, and the access time ring.
  logic [MW-1:0]  meta_mem [FRAME_CNT];
  logic [TIW-1:0] time_mem [FRAME_CNT * MAX_K];

  logic [FW-1:0]  meta_raddr, meta_waddr;
  logic [MW-1:0]  meta_rd_r, meta_wdata;
  logic           meta_we;
  logic [AW-1:0]  time_raddr, time_waddr;
  logic [TIW-1:0] time_rd_r;
  logic           time_we;

  lkfr_pkg::state_t state_r, state_nxt;

  logic [FRAME_CNT-1:0]  present_r, present_nxt;
  logic [FRAME_CNT-1:0]  evict_r, evict_nxt;
  logic [TW-1:0]         total_r, total_nxt;
  logic [TIW-1:0]        now_r, now_nxt;
  logic [lkfr_pkg::K_W-1:0] k_r;
  logic [CW-1:0]         eff_k;

  lkfr_pkg::cmd_t cmd_r, cmd_nxt;
  logic           res_ok_r, res_ok_nxt;
  logic [FW-1:0]  res_vic_r, res_vic_nxt;

  logic           out_valid_r, out_valid_nxt;
  logic           out_ok_r;
  logic [lkfr_pkg::FRAME_W-1:0] out_vic_r;
  logic [lkfr_pkg::COUNT_W-1:0] out_cnt_r;
  logic           out_load;

  // Scan pipeline.
  logic [FW:0]    iss_r, iss_nxt;
  logic           s1_v_r, s1_v_nxt;
  logic [FW-1:0]  s1_f_r, s1_f_nxt;
  logic           s2_v_r, s2_v_nxt;
  logic [FW-1:0]  s2_f_r, s2_f_nxt;
  logic           s2_elig_r, s2_elig_nxt;
  logic           s2_inf_r, s2_inf_nxt;
  logic           found_r, found_nxt;
  logic           best_inf_r, best_inf_nxt;
  logic [TIW-1:0] best_old_r, best_old_nxt;
  logic [FW-1:0]  best_f_r, best_f_nxt;
  logic           take;
  logic           iss_done;

  // Access update intermediates.
  logic [FW-1:0]   cf;
  logic            cur_present;
  logic [CW-1:0]   a_cnt, a_cnt2;
  logic [SW-1:0]   a_old, a_old1, a_old2;
  logic [SUMW-1:0] a_sum;
  logic [SW-1:0]   a_slot;

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    if (s == SW'(MAX_K - 1)) begin
      r = '0;
    end else begin
      r = s + SW'(1);
    end
    return r;
  endfunction

  // Configuration register; K is clamped into 1..MAX_K.
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= lkfr_pkg::K_W'(2);
    end else if (cfg_ch.valid) begin
      k_r <= cfg_ch.data;
    end
  end

  always_comb begin
    if (k_r == '0) begin
      eff_k = CW'(1);
    end else if (5'(k_r) > 5'(MAX_K)) begin
      eff_k = CW'(MAX_K);
    end else begin
      eff_k = CW'(k_r);
    end
  end

  assign cf          = FW'(cmd_r.frame);
  assign cur_present = present_r[cf];
  assign iss_done    = (iss_r == (FW + 1)'(FRAME_CNT));
  assign out_load    = (state_r == lkfr_pkg::ST_DONE) && (!out_valid_r || out_ch.ready);

  // Access arithmetic: ring slot for the new time and the trimmed history.
  always_comb begin
    a_cnt  = cur_present ? meta_rd_r[MW-1:SW] : '0;
    a_old  = cur_present ? meta_rd_r[SW-1:0]  : '0;
    a_sum  = SUMW'(a_old) + SUMW'(a_cnt);
    a_slot = (a_sum >= SUMW'(MAX_K)) ? SW'(a_sum - SUMW'(MAX_K)) : SW'(a_sum);
    if (a_cnt < CW'(MAX_K)) begin
      a_cnt2 = a_cnt + CW'(1);
      a_old1 = a_old;
    end else begin
      a_cnt2 = a_cnt;
      a_old1 = slot_inc(a_old);
    end
    a_old2 = a_old1;
    if (a_cnt2 > eff_k) begin
      a_old2 = slot_inc(a_old1);
      a_cnt2 = a_cnt2 - CW'(1);
    end
  end

  // Candidate selection: infinite distance first, then earliest oldest time.
  always_comb begin
    if (!found_r) begin
      take = 1'b1;
    end else if (s2_inf_r != best_inf_r) begin
      take = s2_inf_r;
    end else begin
      take = (time_rd_r < best_old_r);
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lkfr_pkg::ST_IDLE: begin
        if (head.valid) begin
          state_nxt = lkfr_pkg::ST_EXEC;
        end
      end
      lkfr_pkg::ST_EXEC: begin
        if (cmd_r.op == lkfr_pkg::OP_EVICT) begin
          state_nxt = lkfr_pkg::ST_SCAN;
        end else begin
          state_nxt = lkfr_pkg::ST_DONE;
        end
      end
      lkfr_pkg::ST_SCAN: begin
        if (iss_done && !s1_v_r && !s2_v_r) begin
          state_nxt = lkfr_pkg::ST_EVWR;
        end
      end
      lkfr_pkg::ST_EVWR: begin
        state_nxt = lkfr_pkg::ST_DONE;
      end
      lkfr_pkg::ST_DONE: begin
        if (out_load) begin
          state_nxt = lkfr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lkfr_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    pop          = 1'b0;
    cmd_nxt      = cmd_r;
    present_nxt  = present_r;
    evict_nxt    = evict_r;
    total_nxt    = total_r;
    now_nxt      = now_r;
    res_ok_nxt   = res_ok_r;
    res_vic_nxt  = res_vic_r;
    iss_nxt      = iss_r;
    s1_v_nxt     = 1'b0;
    s1_f_nxt     = s1_f_r;
    s2_v_nxt     = 1'b0;
    s2_f_nxt     = s1_f_r;
    s2_elig_nxt  = present_r[s1_f_r] && evict_r[s1_f_r];
    s2_inf_nxt   = (meta_rd_r[MW-1:SW] < eff_k);
    found_nxt    = found_r;
    best_inf_nxt = best_inf_r;
    best_old_nxt = best_old_r;
    best_f_nxt   = best_f_r;
    meta_raddr   = iss_r[FW-1:0];
    meta_we      = 1'b0;
    meta_waddr   = cf;
    meta_wdata   = {a_cnt2, a_old2};
    time_raddr   = AW'(s1_f_r) * AW'(MAX_K) + AW'(meta_rd_r[SW-1:0]);
    time_we      = 1'b0;
    time_waddr   = AW'(cf) * AW'(MAX_K) + AW'(a_slot);
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      lkfr_pkg::ST_IDLE: begin
        meta_raddr = FW'(head.cmd.frame);
        if (head.valid) begin
          pop     = 1'b1;
          cmd_nxt = head.cmd;
        end
      end
      lkfr_pkg::ST_EXEC: begin
        res_ok_nxt  = 1'b0;
        res_vic_nxt = '0;
        iss_nxt     = '0;
        found_nxt   = 1'b0;
        if (cmd_r.op == lkfr_pkg::OP_EVICT) begin
          res_ok_nxt = 1'b0;
        end else if (cmd_r.frame_ok) begin
          case (cmd_r.op)
            lkfr_pkg::OP_ACCESS: begin
              now_nxt         = now_r + TIW'(1);
              time_we         = 1'b1;
              meta_we         = 1'b1;
              present_nxt[cf] = 1'b1;
              res_ok_nxt      = 1'b1;
            end
            lkfr_pkg::OP_SET: begin
              if (cur_present) begin
                res_ok_nxt = 1'b1;
                evict_nxt[cf] = cmd_r.evictable;
                if (evict_r[cf] && !cmd_r.evictable) begin
                  total_nxt = total_r - TW'(1);
                end else if (!evict_r[cf] && cmd_r.evictable) begin
                  total_nxt = total_r + TW'(1);
                end
              end
            end
            default: begin
              if (cur_present && evict_r[cf]) begin
                res_ok_nxt      = 1'b1;
                present_nxt[cf] = 1'b0;
                evict_nxt[cf]   = 1'b0;
                total_nxt       = total_r - TW'(1);
              end
            end
          endcase
        end
      end
      lkfr_pkg::ST_SCAN: begin
        // Stage 0 issues the count read, stage 1 the time read, stage 2 compares.
        if (!iss_done) begin
          s1_v_nxt = 1'b1;
          s1_f_nxt = iss_r[FW-1:0];
          iss_nxt  = iss_r + (FW + 1)'(1);
        end
        s2_v_nxt = s1_v_r;
        if (s2_v_r && s2_elig_r && take) begin
          found_nxt    = 1'b1;
          best_inf_nxt = s2_inf_r;
          best_old_nxt = time_rd_r;
          best_f_nxt   = s2_f_r;
        end
      end
      lkfr_pkg::ST_EVWR: begin
        res_ok_nxt = found_r;
        if (found_r) begin
          res_vic_nxt           = best_f_r;
          present_nxt[best_f_r] = 1'b0;
          evict_nxt[best_f_r]   = 1'b0;
          total_nxt             = total_r - TW'(1);
        end
      end
      lkfr_pkg::ST_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lkfr_pkg::ST_IDLE;
      present_r   <= '0;
      evict_r     <= '0;
      total_r     <= '0;
      now_r       <= '0;
      out_valid_r <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      iss_r       <= '0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      present_r   <= present_nxt;
      evict_r     <= evict_nxt;
      total_r     <= total_nxt;
      now_r       <= now_nxt;
      out_valid_r <= out_valid_nxt;
      s1_v_r      <= s1_v_nxt;
      s2_v_r      <= s2_v_nxt;
      iss_r       <= iss_nxt;
      found_r     <= found_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    res_ok_r   <= res_ok_nxt;
    res_vic_r  <= res_vic_nxt;
    s1_f_r     <= s1_f_nxt;
    s2_f_r     <= s2_f_nxt;
    s2_elig_r  <= s2_elig_nxt;
    s2_inf_r   <= s2_inf_nxt;
    best_inf_r <= best_inf_nxt;
    best_old_r <= best_old_nxt;
    best_f_r   <= best_f_nxt;
    if (out_load) begin
      out_ok_r  <= res_ok_r;
      out_vic_r <= lkfr_pkg::FRAME_W'(res_vic_r);
      out_cnt_r <= lkfr_pkg::COUNT_W'(total_r);
    end
  end

  // Frame metadata memory.
  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    meta_rd_r <= meta_mem[meta_raddr];
  end

  // Access time memory.
  always_ff @(posedge clk) begin
    if (time_we) begin
      time_mem[time_waddr] <= now_nxt;
    end
    time_rd_r <= time_mem[time_raddr];
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.ok              = out_ok_r;
  assign out_ch.victim_frame    = out_vic_r;
  assign out_ch.evictable_count = out_cnt_r;

endmodule

[src/lru_k_frame_replacer.sv]
// ----------------------------------------------------------------------------
// LRU-K frame replacer
// Buffer frame tracker choosing eviction victims by backward K-distance.
// ----------------------------------------------------------------------------
// Usage:
// Command words enter on in_ch (op, frame, evictable) and each gives exactly
// one result word on out_ch (ok, victim_frame, evictable_count). The K value
// is written through cfg_ch, which is always ready; write it only while idle.
// A two-entry queue separates the accepting front end from the sequencer, so
// new words are taken while the sequencer works or a result waits.
// Access, set and remove pass through the execute and done states after the
// word leaves the queue; evict adds a scan state, which reads one frame's
// count and oldest time per cycle through a 3-stage pipe over all FRAME_CNT
// frames, and then an evict-write state. The sequencer runs one word at a
// time and takes the next only after the last result is loaded. When out_ch
// stalls, the finished result holds in the output register and the sequencer
// waits; the queue keeps accepting until full.
// Reset (rst_n low, synchronous) empties all frames, clears the time counter
// and evictable count, and sets K to 2. No clearing pass is needed.
// ----------------------------------------------------------------------------
module lru_k_frame_replacer (
  input  logic        clk,
  input  logic        rst_n,
  lkfr_in_if.sink     in_ch,
  lkfr_out_if.source  out_ch,
  lkfr_cfg_if.sink    cfg_ch
);

  lkfr_pkg::head_t head;
  logic            pop;

  // Front end: accept and classify.
  lkfr_front u_front (
    .clk  (clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .head (head),
    .pop  (pop)
  );

  // Back end: execute and report.
  lkfr_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .head  (head),
    .pop   (pop),
    .cfg_ch(cfg_ch),
    .out_ch(out_ch)
  );

endmodule

[tb/sv/lru_k_frame_replacer_tb.sv]
// ----------------------------------------------------------------------------
// LRU-K frame replacer testbench
// Drives command words with random gaps, predicts each result word with a
// behavioral LRU-K replacer, and compares every result field by field.
// ----------------------------------------------------------------------------
module lru_k_frame_replacer_tb;

  localparam int FRAMES    = 64;
  localparam int HIST_MAX  = 8;
  localparam int WDOG_MAX  = 4000;

  typedef struct packed {
    lkfr_pkg::op_t                op;
    logic [lkfr_pkg::FRAME_W-1:0] frame;
    logic                         evictable;
  } word_t;

  typedef struct packed {
    logic                         ok;
    logic [lkfr_pkg::FRAME_W-1:0] victim;
    logic [lkfr_pkg::COUNT_W-1:0] count;
  } reply_t;

  logic clk;
  logic rst_n;

  lkfr_in_if  in_ch ();
  lkfr_out_if out_ch ();
  lkfr_cfg_if cfg_ch ();

  lru_k_frame_replacer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predictor state.
  logic [lkfr_pkg::K_W-1:0]     depth_k;
  logic                         present_q [FRAMES];
  logic                         evict_ok_q [FRAMES];
  logic [3:0]                   hits_q [FRAMES];
  logic [2:0]                   head_q [FRAMES];
  logic [lkfr_pkg::TIME_W-1:0]  stamps_q [FRAMES][HIST_MAX];
  logic [lkfr_pkg::TIME_W-1:0]  clock_now;
  logic [lkfr_pkg::COUNT_W-1:0] evictable_now;

  word_t  pending_words[$];
  reply_t expected_replies[$];
  int     errors;
  bit     stim_done;
  bit     calm;
  int     in_gap, out_gap;
  int     wdog;

  // Effective K with the clamp to the legal range.
  function automatic int k_eff();
    if (depth_k == 0) return 1;
    if (depth_k > HIST_MAX) return HIST_MAX;
    return int'(depth_k);
  endfunction

  function automatic void clear_frame(int f);
    present_q[f] = 1'b0;
    evict_ok_q[f] = 1'b0;
    hits_q[f] = '0;
    head_q[f] = '0;
  endfunction

  // Appends a word to the stimulus queue.
  function automatic void put_word(word_t w);
    pending_words.insert(pending_words.size(), w);
  endfunction

  // Applies one command word to the predictor and returns the result word.
  function automatic reply_t replace_step(word_t w);
    reply_t r;
    int k, cnt, f, best;
    bit found, best_inf, inf, take;
    logic [lkfr_pkg::TIME_W-1:0] old, kdist, best_dist, best_old;
    r = '0;
    k = k_eff();
    f = int'(w.frame);
    found = 0; best_inf = 0; best_dist = '0; best_old = '0; best = 0;
    case (w.op)
      lkfr_pkg::OP_ACCESS: begin
        clock_now = clock_now + 1;
        if (!present_q[f]) begin
          clear_frame(f);
          present_q[f] = 1'b1;
        end
        cnt = int'(hits_q[f]);
        stamps_q[f][(int'(head_q[f]) + cnt) % HIST_MAX] = clock_now;
        if (cnt < HIST_MAX) cnt++;
        else head_q[f] = head_q[f] + 1;
        if (cnt > k) begin
          head_q[f] = head_q[f] + 1;
          cnt--;
        end
        hits_q[f] = 4'(cnt);
        r.ok = 1'b1;
      end
      lkfr_pkg::OP_SET: begin
        if (present_q[f]) begin
          if (evict_ok_q[f] && !w.evictable) evictable_now--;
          else if (!evict_ok_q[f] && w.evictable) evictable_now++;
          evict_ok_q[f] = w.evictable;
          r.ok = 1'b1;
        end
      end
      lkfr_pkg::OP_REMOVE: begin
        if (present_q[f] && evict_ok_q[f]) begin
          clear_frame(f);
          evictable_now--;
          r.ok = 1'b1;
        end
      end
      default: begin
        for (int i = 0; i < FRAMES; i++) begin
          if (present_q[i] && evict_ok_q[i]) begin
            old = stamps_q[i][head_q[i]];
            inf = int'(hits_q[i]) < k;
            kdist = inf ? '0 : clock_now - old;
            if (!found) take = 1;
            else if (inf != best_inf) take = inf;
            else if (!inf && kdist != best_dist) take = kdist > best_dist;
            else take = old < best_old;
            if (take) begin
              found = 1; best = i; best_inf = inf; best_dist = kdist; best_old = old;
            end
          end
        end
        if (found) begin
          clear_frame(best);
          evictable_now--;
          r.ok = 1'b1;
          r.victim = lkfr_pkg::FRAME_W'(best);
        end
      end
    endcase
    r.count = evictable_now;
    return r;
  endfunction

  function automatic word_t mk(lkfr_pkg::op_t op, int f, bit ev);
    word_t w;
    w.op = op;
    w.frame = lkfr_pkg::FRAME_W'(f);
    w.evictable = ev;
    return w;
  endfunction

  // Random word: mostly accesses and set-evictable on a small hot set so that
  // many frames become evictable with deep histories.
  function automatic word_t rand_word();
    int sel, f;
    sel = $urandom_range(99);
    f = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(15);
    if (sel < 45) return mk(lkfr_pkg::OP_ACCESS, f, 1'($urandom_range(1)));
    if (sel < 70) return mk(lkfr_pkg::OP_SET, f, ($urandom_range(3) != 0));
    if (sel < 82) return mk(lkfr_pkg::OP_REMOVE, f, 1'($urandom_range(1)));
    return mk(lkfr_pkg::OP_EVICT, $urandom_range(63), 1'($urandom_range(1)));
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Input driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_replies.insert(expected_replies.size(),
                                replace_step({in_ch.op, in_ch.frame, in_ch.evictable}));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (!calm && $urandom_range(9) == 0) begin
          in_gap <= $urandom_range(1, 12) - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          word_t w;
          w = pending_words[0];
          pending_words.delete(0);
          in_ch.valid <= 1'b1;
          in_ch.op <= w.op;
          in_ch.frame <= w.frame;
          in_ch.evictable <= w.evictable;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_replies.size() == 0) begin
          $display("%0t: unexpected result ok=%0b victim=%0d count=%0d", $time,
                   out_ch.ok, out_ch.victim_frame, out_ch.evictable_count);
          errors++;
        end else begin
          reply_t e;
          e = expected_replies[0];
          expected_replies.delete(0);
          if (out_ch.ok !== e.ok) begin
            $display("%0t: ok expected %0b actual %0b", $time, e.ok, out_ch.ok);
            errors++;
          end
          if (out_ch.victim_frame !== e.victim) begin
            $display("%0t: victim_frame expected %0d actual %0d", $time, e.victim,
                     out_ch.victim_frame);
            errors++;
          end
          if (out_ch.evictable_count !== e.count) begin
            $display("%0t: evictable_count expected %0d actual %0d", $time, e.count,
                     out_ch.evictable_count);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(9) == 0) begin
        out_gap <= $urandom_range(1, 12) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any accepted word while work is outstanding.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready) || stim_done) begin
      wdog <= 0;
    end else if (pending_words.size() > 0 || expected_replies.size() > 0
                 || in_ch.valid || cfg_ch.valid) begin
      wdog <= wdog + 1;
      if (wdog + 1 >= WDOG_MAX) begin
        $display("lru_k_frame_replacer_tb: done, errors");
        $finish;
      end
    end else begin
      wdog <= 0;
    end
  end

  // Waits until every queued word is sent and answered, plus the evict latency.
  task automatic drain();
    while (pending_words.size() > 0 || in_ch.valid || expected_replies.size() > 0)
      @(posedge clk);
    repeat (FRAMES + 20) @(posedge clk);
  endtask

  task automatic write_k(int k);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= lkfr_pkg::K_W'(k);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    depth_k = lkfr_pkg::K_W'(k);
  endtask

  // Stimulus sequence.
  initial begin
    int ks[6];
    ks = '{1, 8, 0, 15, 3, 2};
    errors = 0;
    stim_done = 0;
    calm = 0;
    depth_k = 4'd2;
    clock_now = '0;
    evictable_now = '0;
    for (int i = 0; i < FRAMES; i++) begin
      clear_frame(i);
      for (int j = 0; j < HIST_MAX; j++) stamps_q[i][j] = '0;
    end
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = '0;
    in_ch.frame = '0;
    in_ch.evictable = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty evict, absent frames, pinned remove, extremes, infinite distance.
    put_word(mk(lkfr_pkg::OP_EVICT, 63, 1));
    put_word(mk(lkfr_pkg::OP_SET, 63, 1));
    put_word(mk(lkfr_pkg::OP_REMOVE, 0, 0));
    put_word(mk(lkfr_pkg::OP_ACCESS, 0, 0));
    put_word(mk(lkfr_pkg::OP_ACCESS, 63, 1));
    put_word(mk(lkfr_pkg::OP_ACCESS, 63, 0));
    put_word(mk(lkfr_pkg::OP_ACCESS, 42, 0));
    put_word(mk(lkfr_pkg::OP_ACCESS, 42, 0));
    put_word(mk(lkfr_pkg::OP_REMOVE, 0, 0));
    put_word(mk(lkfr_pkg::OP_SET, 0, 1));
    put_word(mk(lkfr_pkg::OP_SET, 0, 1));
    put_word(mk(lkfr_pkg::OP_SET, 63, 1));
    put_word(mk(lkfr_pkg::OP_SET, 42, 1));
    put_word(mk(lkfr_pkg::OP_EVICT, 0, 0));
    put_word(mk(lkfr_pkg::OP_EVICT, 0, 0));
    put_word(mk(lkfr_pkg::OP_SET, 42, 0));
    put_word(mk(lkfr_pkg::OP_REMOVE, 42, 0));
    put_word(mk(lkfr_pkg::OP_SET, 42, 1));
    put_word(mk(lkfr_pkg::OP_REMOVE, 42, 1));
    put_word(mk(lkfr_pkg::OP_EVICT, 0, 0));
    put_word(mk(lkfr_pkg::OP_ACCESS, 21, 0));
    // Sender holds off until every expected result has come.
    drain();

    // Random phases, one per K setting; lowering K leaves long histories behind.
    for (int p = 0; p < 6; p++) begin
      write_k(ks[p]);
      if (p == 5) calm = 1;
      for (int n = 0; n < 270; n++) put_word(rand_word());
      drain();
    end

    stim_done = 1;
    if (errors == 0) begin
      $display("lru_k_frame_replacer_tb: done, clean");
    end else begin
      $display("lru_k_frame_replacer_tb: done, errors");
    end
    $finish;
  end

endmodule

[files.f]
src/lkfr_pkg.sv
src/lkfr_if.sv
src/lkfr_front.sv
src/lkfr_back.sv
src/lru_k_frame_replacer.sv
tb/sv/lru_k_frame_replacer_tb.sv
